// ===== rtl/core/ppi_pkg.sv =====
// Shared types and constants for the piecewise profile interpolator.
// No dependencies.
package ppi_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [3:0] REG_POINT_COUNT = 4'd0;
  localparam logic [3:0] REG_TOP_ALTITUDE = 4'd1;

  localparam logic [16:0] FRAC_ONE = 17'h10000;
  localparam logic signed [63:0] PRESHIFT_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic cmd;
    logic [3:0] slot;
    logic signed [63:0] breakpoint_altitude;
    logic signed [31:0] load_density;
    logic signed [31:0] load_pressure;
    logic signed [31:0] load_temperature;
    logic signed [63:0] query_altitude;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample_density;
    logic signed [31:0] sample_pressure;
    logic signed [31:0] sample_temperature;
    logic above_top;
  } out_t;

  typedef struct packed {
    logic signed [31:0] dens_a;
    logic signed [31:0] dens_b;
    logic signed [31:0] pres_a;
    logic signed [31:0] pres_b;
    logic signed [31:0] temp_a;
    logic signed [31:0] temp_b;
    logic signed [31:0] last_temp;
    logic above;
  } val_t;

  typedef struct packed {
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    val_t v;
  } sel_t;

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] d;
    logic [15:0] q;
    logic fix;
    logic [16:0] t_fix;
    val_t v;
  } div_t;

endpackage

// ===== rtl/core/piecewise_profile_interpolator.sv =====
// Top level of the piecewise profile interpolator: stall pipeline, Q16 divider.
// Depends on ppi_pkg, ppi_table and ppi_lerp.
//
// Usage:
//   in channel: a transaction with cmd = load writes one breakpoint at slot and
//   gives no result; cmd = sample gives exactly one out transaction.
//   cfg channel: cfg_index 0 is the point count, 1 is top_altitude; other
//   indexes are dropped. cfg_ready is always high; write only while idle.
//   A sample reaches out through 15 register stages: input register, table
//   select, offset/span subtract, fraction setup, eight two-bit divider
//   stages, two multiply/saturate stages and the output register. One
//   transaction is accepted per cycle while out is not stalled, so the
//   sustained rate is one item per cycle; the divider stages set the depth.
//   A load is visible to every sample accepted after it.
//   Reset clears all valid bits and the registers to point count 2 and
//   top_altitude 0; breakpoints are undefined until loaded.
//   When the receiver stalls, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated.
module piecewise_profile_interpolator #(
  parameter int MAX_POINTS = ppi_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ppi_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ppi_pkg::out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import ppi_pkg::*;

  logic en;
  logic [4:0] point_count;
  logic signed [63:0] top_alt;

  logic v0;
  logic signed [63:0] q0;
  logic v1;
  sel_t s1;
  sel_t sel;
  logic signed [63:0] q1;
  logic v2;
  logic signed [63:0] off2;
  logic signed [63:0] span2;
  val_t val2;
  logic [DIV_STAGES:0] vd;
  div_t dv [DIV_STAGES+1];
  logic [16:0] t_l;
  logic vl1;
  logic vl2;
  val_t vall1;
  val_t vall2;
  logic signed [31:0] y_d;
  logic signed [31:0] y_p;
  logic signed [31:0] y_t;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 5'd2;
      top_alt <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_POINT_COUNT) point_count <= cfg_data[4:0];
      else if (cfg_index == REG_TOP_ALTITUDE) top_alt <= cfg_data;
    end
  end

  ppi_table #(.MAX_POINTS(MAX_POINTS)) u_table (
    .clk(clk),
    .wr_en(in_valid && in_ready && (in_data.cmd == CMD_LOAD)),
    .wr_slot(in_data.slot),
    .wr_alt(in_data.breakpoint_altitude),
    .wr_dens(in_data.load_density),
    .wr_pres(in_data.load_pressure),
    .wr_temp(in_data.load_temperature),
    .point_count(point_count),
    .top_alt(top_alt),
    .query(q0),
    .sel(sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd <= '0;
      vl1 <= 1'b0;
      vl2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid && (in_data.cmd == CMD_SAMPLE);
      v1 <= v0;
      v2 <= v1;
      vd <= {vd[DIV_STAGES-1:0], v2};
      vl1 <= vd[DIV_STAGES];
      vl2 <= vl1;
      out_valid <= vl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= (in_data.query_altitude < 0) ? '0 : in_data.query_altitude;
      s1 <= sel;
      q1 <= q0;
      off2 <= q1 - s1.lo;
      span2 <= s1.hi - s1.lo;
      val2 <= s1.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].v <= val2;
      dv[0].q <= '0;
      if ((span2 <= 0) || (off2 <= 0)) begin
        dv[0].fix <= 1'b1;
        dv[0].t_fix <= '0;
        dv[0].r <= 64'(off2);
        dv[0].d <= 64'(span2);
      end else if (off2 >= span2) begin
        dv[0].fix <= 1'b1;
        dv[0].t_fix <= FRAC_ONE;
        dv[0].r <= 64'(off2);
        dv[0].d <= 64'(span2);
      end else if (off2 > PRESHIFT_LIMIT) begin
        dv[0].fix <= 1'b0;
        dv[0].t_fix <= '0;
        dv[0].r <= 64'(off2) >> 4;
        dv[0].d <= 64'(span2) >> 4;
      end else begin
        dv[0].fix <= 1'b0;
        dv[0].t_fix <= '0;
        dv[0].r <= 64'(off2);
        dv[0].d <= 64'(span2);
      end
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [63:0] r_n;
    logic [15:0] q_n;
    logic [64:0] r2;

    always_comb begin
      r_n = dv[k].r;
      q_n = dv[k].q;
      for (int j = 0; j < DIV_BITS; j++) begin
        r2 = {r_n, 1'b0};
        q_n = {q_n[14:0], 1'b0};
        if (r2 >= {1'b0, dv[k].d}) begin
          r2 = r2 - {1'b0, dv[k].d};
          q_n[0] = 1'b1;
        end
        r_n = r2[63:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1].r <= r_n;
        dv[k+1].d <= dv[k].d;
        dv[k+1].q <= q_n;
        dv[k+1].fix <= dv[k].fix;
        dv[k+1].t_fix <= dv[k].t_fix;
        dv[k+1].v <= dv[k].v;
      end
    end
  end

  assign t_l = dv[DIV_STAGES].fix ? dv[DIV_STAGES].t_fix : {1'b0, dv[DIV_STAGES].q};

  ppi_lerp u_lerp_d (
    .clk(clk), .en(en), .a(dv[DIV_STAGES].v.dens_a), .b(dv[DIV_STAGES].v.dens_b),
    .t(t_l), .y(y_d)
  );
  ppi_lerp u_lerp_p (
    .clk(clk), .en(en), .a(dv[DIV_STAGES].v.pres_a), .b(dv[DIV_STAGES].v.pres_b),
    .t(t_l), .y(y_p)
  );
  ppi_lerp u_lerp_t (
    .clk(clk), .en(en), .a(dv[DIV_STAGES].v.temp_a), .b(dv[DIV_STAGES].v.temp_b),
    .t(t_l), .y(y_t)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      vall1 <= dv[DIV_STAGES].v;
      vall2 <= vall1;
      if (vall2.above) begin
        out_data.sample_density <= '0;
        out_data.sample_pressure <= '0;
        out_data.sample_temperature <= vall2.last_temp;
        out_data.above_top <= 1'b1;
      end else begin
        out_data.sample_density <= y_d;
        out_data.sample_pressure <= y_p;
        out_data.sample_temperature <= y_t;
        out_data.above_top <= 1'b0;
      end
    end
  end

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vd[DIV_STAGES] |-> (t_l <= FRAC_ONE))
    else $error("fraction above one");

  a_above_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.above_top) |->
      (out_data.sample_density == 0 && out_data.sample_pressure == 0))
    else $error("above ceiling result not zeroed");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (vl2 == $past(vl2) && vd == $past(vd)))
    else $error("pipeline moved while stalled");

endmodule

// ===== rtl/core/ppi_table.sv =====
// Breakpoint storage with bracketing-pair search and operand selection.
// Depends on ppi_pkg.
module ppi_table #(
  parameter int MAX_POINTS = ppi_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [3:0] wr_slot,
  input  logic signed [63:0] wr_alt,
  input  logic signed [31:0] wr_dens,
  input  logic signed [31:0] wr_pres,
  input  logic signed [31:0] wr_temp,
  input  logic [4:0] point_count,
  input  logic signed [63:0] top_alt,
  input  logic signed [63:0] query,
  output ppi_pkg::sel_t sel
);
  import ppi_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  logic signed [63:0] alt [MAX_POINTS];
  logic signed [31:0] dens [MAX_POINTS];
  logic signed [31:0] pres [MAX_POINTS];
  logic signed [31:0] temp [MAX_POINTS];

  logic [IW-1:0] wa;
  logic [IW-1:0] last;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx1;
  logic signed [63:0] top_eff;
  int cnt;

  assign wa = IW'(wr_slot);

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) < MAX_POINTS)) begin
      alt[wa] <= wr_alt;
      dens[wa] <= wr_dens;
      pres[wa] <= wr_pres;
      temp[wa] <= wr_temp;
    end
  end

  always_comb begin
    cnt = 32'(point_count);
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    last = IW'(cnt - 1);
    idx = IW'(cnt - 2);
    for (int i = MAX_POINTS - 1; i >= 1; i--) begin
      if ((i < cnt) && (query < alt[i])) idx = IW'(i - 1);
    end
    idx1 = idx + 1'b1;
    top_eff = (top_alt <= 0) ? alt[last] : top_alt;
    sel.lo = alt[idx];
    sel.hi = alt[idx1];
    sel.v.dens_a = dens[idx];
    sel.v.dens_b = dens[idx1];
    sel.v.pres_a = pres[idx];
    sel.v.pres_b = pres[idx1];
    sel.v.temp_a = temp[idx];
    sel.v.temp_b = temp[idx1];
    sel.v.last_temp = temp[last];
    sel.v.above = (query >= top_eff);
  end

endmodule

// ===== rtl/core/ppi_lerp.sv =====
// Two-stage saturating linear blend a + floor((b - a) * t / 65536).
// Depends on ppi_pkg.
module ppi_lerp (
  input  logic clk,
  input  logic en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [16:0] t,
  output logic signed [31:0] y
);
  import ppi_pkg::*;

  logic signed [50:0] prod;
  logic signed [31:0] a_q;
  logic signed [32:0] diff;
  logic signed [35:0] sum;

  assign diff = 33'(b) - 33'(a);
  assign sum = 36'(a_q) + 36'(prod >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 51'(diff * $signed({1'b0, t}));
      a_q <= a;
      if (sum > 36'sh0_7FFF_FFFF) y <= 32'sh7FFF_FFFF;
      else if (sum < -36'sh0_8000_0000) y <= 32'sh8000_0000;
      else y <= sum[31:0];
    end
  end

endmodule

// ===== bench/piecewise_profile_interpolator_test.sv =====
// Self-checking bench for piecewise_profile_interpolator: random table loads, samples
// and register settings checked against an in-bench predictor of the interpolation.
// Depends on ppi_pkg and the piecewise_profile_interpolator RTL.
module piecewise_profile_interpolator_test;
  import ppi_pkg::*;

  localparam logic [3:0] REG_SPARE = 4'd9;
  localparam logic signed [63:0] ALT_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ALT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_index;
  logic [63:0] cfg_data;

  piecewise_profile_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [63:0] alt_tab [16];
  logic signed [31:0] dens_tab [16];
  logic signed [31:0] pres_tab [16];
  logic signed [31:0] temp_tab [16];
  logic [4:0] seg_reg;
  logic signed [63:0] top_reg;

  in_t pending_items[$];
  out_t expected_samples[$];
  int errors = 0;
  int gap_left;
  int stall_left;
  int hold_left;
  int samples_seen = 0;
  bit hold_done = 1'b0;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [16:0] frac_of_span(logic signed [63:0] num,
                                               logic signed [63:0] den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] r;
    logic [15:0] q;
    if (den <= 0 || num <= 0) return 17'd0;
    if (num >= den) return FRAC_ONE;
    n = num;
    d = den;
    if (num > PRESHIFT_LIMIT) begin
      n = n >> 4;
      d = d >> 4;
    end
    if (d == 0) return 17'd0;
    r = n;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return {1'b0, q};
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               logic [16:0] t);
    logic signed [63:0] prod;
    logic signed [63:0] v;
    prod = (64'(b) - 64'(a)) * $signed({47'd0, t});
    v = 64'(a) + (prod >>> 16);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_t sample_profile(logic signed [63:0] query);
    out_t r;
    int cnt;
    int idx;
    logic signed [63:0] q;
    logic signed [63:0] top;
    logic [16:0] t;
    cnt = (seg_reg < 2) ? 2 : (seg_reg > 16) ? 16 : int'(seg_reg);
    q = (query < 0) ? 64'sd0 : query;
    top = (top_reg <= 0) ? alt_tab[cnt-1] : top_reg;
    if (q >= top) begin
      r.sample_density = '0;
      r.sample_pressure = '0;
      r.sample_temperature = temp_tab[cnt-1];
      r.above_top = 1'b1;
      return r;
    end
    idx = cnt - 2;
    for (int i = 1; i < cnt; i++) begin
      if (q < alt_tab[i]) begin
        idx = i - 1;
        break;
      end
    end
    t = frac_of_span(q - alt_tab[idx], alt_tab[idx+1] - alt_tab[idx]);
    r.sample_density = blend(dens_tab[idx], dens_tab[idx+1], t);
    r.sample_pressure = blend(pres_tab[idx], pres_tab[idx+1], t);
    r.sample_temperature = blend(temp_tab[idx], temp_tab[idx+1], t);
    r.above_top = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_LOAD) begin
          alt_tab[in_data.slot] = in_data.breakpoint_altitude;
          dens_tab[in_data.slot] = in_data.load_density;
          pres_tab[in_data.slot] = in_data.load_pressure;
          temp_tab[in_data.slot] = in_data.load_temperature;
        end else begin
          expected_samples.push_back(sample_profile(in_data.query_altitude));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch on %s: expected %h, got %h", field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          report_mismatch("sample transaction count", 32'd0, 32'd1);
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_density !== want.sample_density)
            report_mismatch("density", want.sample_density, out_data.sample_density);
          if (out_data.sample_pressure !== want.sample_pressure)
            report_mismatch("pressure", want.sample_pressure, out_data.sample_pressure);
          if (out_data.sample_temperature !== want.sample_temperature)
            report_mismatch("temperature", want.sample_temperature,
                            out_data.sample_temperature);
          if (out_data.above_top !== want.above_top)
            report_mismatch("above_top", 32'(want.above_top), 32'(out_data.above_top));
        end
      end
      if (!hold_done && samples_seen >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) begin
          stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic in_t load_item(logic [3:0] slot, logic signed [63:0] alt,
                                    logic signed [31:0] d, logic signed [31:0] p,
                                    logic signed [31:0] t);
    in_t it;
    it.cmd = CMD_LOAD;
    it.slot = slot;
    it.breakpoint_altitude = alt;
    it.load_density = d;
    it.load_pressure = p;
    it.load_temperature = t;
    it.query_altitude = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_t sample_item(logic signed [63:0] q);
    in_t it;
    it.cmd = CMD_SAMPLE;
    it.slot = 4'($urandom);
    it.breakpoint_altitude = {$urandom, $urandom};
    it.load_density = $urandom;
    it.load_pressure = $urandom;
    it.load_temperature = $urandom;
    it.query_altitude = q;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_POINT_COUNT) seg_reg = value[4:0];
    else if (idx == REG_TOP_ALTITUDE) top_reg = value;
  endtask

  initial begin
    logic signed [63:0] plan [16];
    logic signed [63:0] q;
    logic [63:0] span;
    logic [63:0] top_pick;
    int kind;
    int seg;
    int i;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    seg_reg = 5'd2;
    top_reg = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    pending_items.push_back(load_item(4'd0, ALT_MIN, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    pending_items.push_back(load_item(4'd1, -64'sd327680, 32'sh7FFF_FFFF,
                                      32'sh8000_0000, 32'sh0001_0000));
    for (i = 2; i < 15; i++)
      pending_items.push_back(load_item(4'(i), 64'(i) <<< 20, $urandom, $urandom, $urandom));
    pending_items.push_back(load_item(4'd15, ALT_MAX, 32'sh7FFF_FFFF, 0, 32'sh8000_0000));
    pending_items.push_back(sample_item(ALT_MIN));
    pending_items.push_back(sample_item(-64'sd1));
    pending_items.push_back(sample_item(64'sd0));
    pending_items.push_back(sample_item(ALT_MAX));
    pending_items.push_back(sample_item(-64'sd327680));
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      steady = (phase % 4 == 3);
      kind = $urandom_range(0, 9);
      plan[0] = {$urandom, $urandom} >>> $urandom_range(8, 40);
      for (i = 1; i < 16; i++) begin
        if (kind < 3)
          plan[i] = ALT_MIN + (64'(i) <<< 60) - 64'($urandom_range(0, 1000)) - 1;
        else if (kind < 9)
          plan[i] = plan[i-1] + 64'($urandom_range(1, 1 << $urandom_range(1, 24)));
        else
          plan[i] = {$urandom, $urandom};
      end
      if (kind < 3) plan[0] = ALT_MIN + 64'($urandom_range(0, 1000));
      for (i = 0; i < 16; i++)
        pending_items.push_back(load_item(4'(i), plan[i], $urandom, $urandom, $urandom));
      wait_idle();

      case (phase)
        0: seg = 0;
        1: seg = 1;
        2: seg = 16;
        3: seg = 17;
        4: seg = 31;
        default: seg = $urandom_range(2, 16);
      endcase
      write_reg(REG_POINT_COUNT, 64'(seg));
      case ($urandom_range(0, 5))
        0: top_pick = 0;
        1: top_pick = ALT_MIN;
        2: top_pick = ALT_MAX;
        3: top_pick = -64'sd65536;
        default: top_pick = plan[$urandom_range(1, 15)];
      endcase
      write_reg(REG_TOP_ALTITUDE, top_pick);
      if (phase % 3 == 0) write_reg(REG_SPARE, {$urandom, $urandom});

      for (int k = 0; k < 95; k++) begin
        i = $urandom_range(0, 14);
        case ($urandom_range(0, 9))
          0: q = {$urandom, $urandom};
          1: q = plan[$urandom_range(0, 15)];
          2: q = -64'($urandom_range(1, 1000));
          3: q = plan[15] + 64'($urandom_range(0, 1 << 20));
          default: begin
            span = plan[i+1] - plan[i];
            q = (span == 0) ? plan[i] : plan[i] + 64'({$urandom, $urandom} % span);
          end
        endcase
        pending_items.push_back(sample_item(q));
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
